@@ design/ptcomp_pkg.sv @@
// ptcomp_pkg: shared types and constants for the pressure/temperature compensation core
// register index codes, pipeline depth and fixed temperature thresholds
// no dependencies
package ptcomp_pkg;

  typedef enum logic [2:0] {
    REG_SENS    = 3'd0,
    REG_OFF     = 3'd1,
    REG_SENS_TC = 3'd2,
    REG_OFF_TC  = 3'd3,
    REG_TREF    = 3'd4,
    REG_TSLOPE  = 3'd5
  } cfg_reg_e;

  localparam int unsigned NumStages = 10;

  // first-order temperature is TempRef plus the slope term
  localparam logic signed [19:0] TempRef = 20'sd2000;
  // very-low threshold seen from the slope term: -1500 - 2000
  localparam logic signed [17:0] VlowSlope = -18'sd3500;
  // offset from the slope term to (TEMP + 1500)
  localparam logic signed [18:0] VlowShift = 19'sd3500;

endpackage

@@ design/pressure_temp_compensation_core.sv @@
// pressure_temp_compensation_core: second-order compensation of raw 24-bit pressure and
// temperature readings with six calibration words held in configuration registers
// depends on ptcomp_pkg
//
// One reading pair enters and one compensated word (pressure in 0.1 mbar, temperature in
// 0.01 degC) leaves per clock while the output is not stalled. The ten register stages
// of the datapath are difference, coefficient products, first-order terms, squares,
// second-order corrections, two partial products of the pressure multiply, their sum, a
// truncating shift, the offset subtraction and a second one. Any stage holding a bubble
// takes a new word even while the output is stalled. The calibration words are read live
// by the first three stages, so write them only while no word is in flight.
module pressure_temp_compensation_core
  import ptcomp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // reading pairs
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        raw_pressure_i,
  input  logic [23:0]        raw_temperature_i,
  // compensated results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pressure_tenth_mbar_o,
  output logic signed [31:0] temp_centideg_o,
  // calibration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // calibration registers
  logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SENS:    c1_q <= cfg_data_i;
        REG_OFF:     c2_q <= cfg_data_i;
        REG_SENS_TC: c3_q <= cfg_data_i;
        REG_OFF_TC:  c4_q <= cfg_data_i;
        REG_TREF:    c5_q <= cfg_data_i;
        REG_TSLOPE:  c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or the next stage loads
  logic [NumStages:1]   v_q;
  logic [NumStages:1]   v_in;
  logic [NumStages+1:1] en;

  always_comb begin
    en[NumStages+1] = !out_stall_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NumStages-1:1], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[NumStages];

  // stage registers
  logic        [23:0] d1_q1, d1_q2, d1_q3, d1_q4, d1_q5;
  logic signed [24:0] dt_q1;
  logic signed [41:0] mt_q2, moff_q2, msens_q2;
  logic        [47:0] dsq_q2;
  logic signed [17:0] tl_q3;
  logic signed [35:0] off_q3, off_q4;
  logic signed [34:0] sens_q3, sens_q4;
  logic        [16:0] ti_q3;
  logic               hi_q3, vlow_q3, hi_q4, vlow_q4;
  logic        [33:0] dev_q4, e_q4;
  logic signed [19:0] t_q4, t_q5, t_q6, t_q7, t_q8, t_q9;
  logic signed [38:0] off2_q5, off2_q6, off2_q7, off2_q8, sens2_q5;
  logic        [43:0] pplo_q6;
  logic signed [43:0] pphi_q6;
  logic signed [63:0] prod_q7;
  logic signed [42:0] q1_q8;
  logic signed [44:0] pnum_q9;
  logic signed [31:0] p_q10, t_q10;

  // next values
  logic signed [24:0] dt_d;
  logic signed [41:0] mt_d, moff_d, msens_d;
  logic signed [49:0] dsq_full;
  logic signed [41:0] mt_b, moff_b, msens_b;
  logic signed [17:0] tl_d;
  logic signed [35:0] off_d;
  logic signed [34:0] sens_d;
  logic        [49:0] dsq3;
  logic        [16:0] ti_d;
  logic               hi_d, vlow_d;
  logic signed [18:0] tv;
  logic signed [35:0] dev_full;
  logic signed [37:0] e_full;
  logic signed [19:0] t_d;
  logic        [35:0] dev3;
  logic        [36:0] dev5, e7;
  logic        [35:0] e4;
  logic        [37:0] offi;
  logic        [36:0] senswi;
  logic signed [38:0] off2_d, sens2_d;
  logic        [43:0] pplo_d;
  logic signed [43:0] pphi_d;
  logic signed [63:0] prod_d, prod_b;
  logic signed [42:0] q1_d;
  logic signed [44:0] pnum_d, pnum_b;
  logic signed [31:0] p_d;

  always_comb begin
    // stage 1: temperature difference
    dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, c5_q, 8'b0});

    // stage 2: coefficient products and dT squared
    mt_d     = $signed({1'b0, c6_q}) * dt_q1;
    moff_d   = $signed({1'b0, c4_q}) * dt_q1;
    msens_d  = $signed({1'b0, c3_q}) * dt_q1;
    dsq_full = dt_q1 * dt_q1;

    // stage 3: first-order terms, divisions truncate toward zero
    mt_b    = mt_q2 + (mt_q2[41] ? 42'sd8388607 : 42'sd0);
    tl_d    = mt_b[40:23];
    moff_b  = moff_q2 + (moff_q2[41] ? 42'sd127 : 42'sd0);
    off_d   = $signed({4'b0, c2_q, 16'b0}) + $signed({moff_b[41], moff_b[41:7]});
    msens_b = msens_q2 + (msens_q2[41] ? 42'sd255 : 42'sd0);
    sens_d  = $signed({4'b0, c1_q, 15'b0}) + $signed({msens_b[41], msens_b[41:8]});
    hi_d    = !tl_d[17];
    vlow_d  = tl_d < VlowSlope;
    dsq3    = {2'b0, dsq_q2} + {1'b0, dsq_q2, 1'b0};
    ti_d    = hi_d ? {5'b0, dsq_q2[47:36]} : dsq3[49:33];

    // stage 4: squares of the temperature deviations, final temperature
    tv       = {tl_q3[17], tl_q3} + VlowShift;
    dev_full = tl_q3 * tl_q3;
    e_full   = tv * tv;
    t_d      = {{2{tl_q3[17]}}, tl_q3} + TempRef - $signed({3'b0, ti_q3});

    // stage 5: second-order offset and sensitivity corrections
    dev3   = {1'b0, dev_q4, 1'b0} + {2'b0, dev_q4};
    dev5   = {1'b0, dev_q4, 2'b0} + {3'b0, dev_q4};
    e7     = {e_q4, 3'b0} - {3'b0, e_q4};
    e4     = {e_q4, 2'b0};
    if (hi_q4) begin
      offi   = {8'b0, dev_q4[33:4]};
      senswi = '0;
    end else begin
      offi   = {3'b0, dev3[35:1]} + (vlow_q4 ? {1'b0, e7} : 38'd0);
      senswi = {3'b0, dev5[36:3]} + (vlow_q4 ? {1'b0, e4} : 37'd0);
    end
    off2_d  = 39'(off_q4) - $signed({1'b0, offi});
    sens2_d = 39'(sens_q4) - $signed({2'b0, senswi});

    // stage 6: D1 * SENS split into two narrow partial products
    pplo_d = 44'(d1_q5) * 44'(sens2_q5[19:0]);
    pphi_d = $signed({1'b0, d1_q5}) * $signed(sens2_q5[38:20]);

    // stage 7: recombine
    prod_d = $signed({pphi_q6, 20'b0}) + $signed({20'b0, pplo_q6});

    // stage 8: divide by 2^21
    prod_b = prod_q7 + (prod_q7[63] ? 64'sd2097151 : 64'sd0);
    q1_d   = prod_b[63:21];

    // stage 9: remove offset
    pnum_d = 45'(q1_q8) - 45'(off2_q8);

    // stage 10: divide by 2^13
    pnum_b = pnum_q9 + (pnum_q9[44] ? 45'sd8191 : 45'sd0);
    p_d    = pnum_b[44:13];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_q1 <= raw_pressure_i;
      dt_q1 <= dt_d;
    end
    if (en[2]) begin
      d1_q2    <= d1_q1;
      mt_q2    <= mt_d;
      moff_q2  <= moff_d;
      msens_q2 <= msens_d;
      dsq_q2   <= dsq_full[47:0];
    end
    if (en[3]) begin
      d1_q3   <= d1_q2;
      tl_q3   <= tl_d;
      off_q3  <= off_d;
      sens_q3 <= sens_d;
      ti_q3   <= ti_d;
      hi_q3   <= hi_d;
      vlow_q3 <= vlow_d;
    end
    if (en[4]) begin
      d1_q4   <= d1_q3;
      off_q4  <= off_q3;
      sens_q4 <= sens_q3;
      hi_q4   <= hi_q3;
      vlow_q4 <= vlow_q3;
      dev_q4  <= dev_full[33:0];
      // only read on the very-low path, where it fits
      e_q4    <= e_full[33:0];
      t_q4    <= t_d;
    end
    if (en[5]) begin
      d1_q5    <= d1_q4;
      off2_q5  <= off2_d;
      sens2_q5 <= sens2_d;
      t_q5     <= t_q4;
    end
    if (en[6]) begin
      pplo_q6 <= pplo_d;
      pphi_q6 <= pphi_d;
      off2_q6 <= off2_q5;
      t_q6    <= t_q5;
    end
    if (en[7]) begin
      prod_q7 <= prod_d;
      off2_q7 <= off2_q6;
      t_q7    <= t_q6;
    end
    if (en[8]) begin
      q1_q8   <= q1_d;
      off2_q8 <= off2_q7;
      t_q8    <= t_q7;
    end
    if (en[9]) begin
      pnum_q9 <= pnum_d;
      t_q9    <= t_q8;
    end
    if (en[10]) begin
      p_q10 <= p_d;
      t_q10 <= 32'(t_q9);
    end
  end

  assign pressure_tenth_mbar_o = p_q10;
  assign temp_centideg_o       = t_q10;

  // an empty output stage lets every stage advance
  a_empty_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled although output stage is empty");

  // a full pipeline against a stalled output holds the input
  a_full_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && out_stall_i) |-> in_stall_o)
    else $error("full pipeline accepted a word");

  // an accepted word occupies the first stage next cycle
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[1])
    else $error("accepted word lost at stage 1");

  // high and very-low temperature cases exclude each other
  a_hi_vlow_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> !(hi_q4 && vlow_q4))
    else $error("high and very-low temperature both flagged");

  // a delivered word is replaced by the one behind it
  a_output_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && v_q[NumStages-1]) |=> out_valid_o)
    else $error("word dropped between last two stages");

endmodule

@@ tb/sv/pressure_temp_compensation_core_test.sv @@
// pressure_temp_compensation_core_test: self-checking bench for the compensation core
// drives reading pairs and calibration writes, predicts every word and checks it at the output
// depends on ptcomp_pkg and pressure_temp_compensation_core
module pressure_temp_compensation_core_test;
  import ptcomp_pkg::*;

  typedef struct packed {
    logic signed [31:0] pressure_tenth_mbar;
    logic signed [31:0] temp_centideg;
  } comp_word_t;

  // last index past the calibration words, writes there must be dropped
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam int         NumCal     = 6;

  localparam longint TempRefC  = 2000;
  localparam longint TempVlowC = -1500;
  localparam longint TempDiv   = 64'sd8388608;
  localparam longint TiHighDiv = 64'sd137438953472;
  localparam longint TiLowDiv  = 64'sd8589934592;
  localparam longint SensDiv   = 64'sd2097152;
  localparam longint PresDiv   = 64'sd8192;

  localparam int IdleLimit     = 4000;
  localparam int DrainCycles   = NumStages + 6;
  localparam int RandPhases    = 10;
  localparam int PhaseItems    = 140;
  localparam int PauseItems    = 40;
  localparam int FullRateItems = 250;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [23:0]        raw_p;
  logic [23:0]        raw_t;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] p_out;
  logic signed [31:0] t_out;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  // calibration words as the core should hold them
  logic [15:0] cal [NumCal];
  comp_word_t  expected_words [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  bit          gaps_on     = 1'b0;
  bit          stall_on    = 1'b0;

  pressure_temp_compensation_core u_top (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .raw_pressure_i        (raw_p),
    .raw_temperature_i     (raw_t),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .pressure_tenth_mbar_o (p_out),
    .temp_centideg_o       (t_out),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic comp_word_t compensate(input logic [23:0] d1_raw, input logic [23:0] d2_raw);
    longint     d1, d2, dt, temp1, off, sens, dev, vlow, ti, offi, sensi, pres;
    comp_word_t w;
    d1    = longint'(d1_raw);
    d2    = longint'(d2_raw);
    dt    = d2 - longint'(cal[REG_TREF]) * 256;
    temp1 = TempRefC + (longint'(cal[REG_TSLOPE]) * dt) / TempDiv;
    off   = longint'(cal[REG_OFF]) * 65536 + (longint'(cal[REG_OFF_TC]) * dt) / 128;
    sens  = longint'(cal[REG_SENS]) * 32768 + (longint'(cal[REG_SENS_TC]) * dt) / 256;
    dev   = (temp1 - TempRefC) * (temp1 - TempRefC);
    if (temp1 >= TempRefC) begin
      ti    = (2 * dt * dt) / TiHighDiv;
      offi  = dev / 16;
      sensi = 0;
    end else begin
      ti    = (3 * dt * dt) / TiLowDiv;
      offi  = (3 * dev) / 2;
      sensi = (5 * dev) / 8;
      if (temp1 < TempVlowC) begin
        vlow  = (temp1 - TempVlowC) * (temp1 - TempVlowC);
        offi  = offi + 7 * vlow;
        sensi = sensi + 4 * vlow;
      end
    end
    pres = ((d1 * (sens - sensi)) / SensDiv - (off - offi)) / PresDiv;
    w.pressure_tenth_mbar = 32'(pres);
    w.temp_centideg       = 32'(temp1 - ti);
    return w;
  endfunction

  function automatic logic [23:0] rand_word24();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_cal_word();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // input accept, output check and watchdog, all on the rising edge
  always @(posedge clk) begin
    comp_word_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(compensate(raw_p, raw_t));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: expected none, actual pressure %0d temp %0d",
                   $time, p_out, t_out);
        end else begin
          want = expected_words.pop_front();
          if (p_out !== want.pressure_tenth_mbar) begin
            mismatches++;
            $display("%0t pressure_tenth_mbar mismatch: expected %0d actual %0d",
                     $time, want.pressure_tenth_mbar, p_out);
          end
          if (t_out !== want.temp_centideg) begin
            mismatches++;
            $display("%0t temp_centideg mismatch: expected %0d actual %0d",
                     $time, want.temp_centideg, t_out);
          end
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[pressure_temp_compensation_core] ERROR");
        $finish;
      end
    end
  end

  // output back-pressure in random bursts while stall_on is set
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_p    <= d1;
    raw_t    <= d2;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random_reading();
    logic [23:0] d2;
    case ($urandom_range(0, 3))
      // close to the reference point, where the branch edges sit
      0:       d2 = {cal[REG_TREF], 8'h00} + 24'($urandom_range(0, 262143)) - 24'd131072;
      1:       d2 = rand_word24();
      default: d2 = 24'($urandom);
    endcase
    send_reading(rand_word24(), d2);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);
  endtask

  // core must be idle; also pokes the spare indexes with junk
  task automatic load_calibration(input logic [15:0] c_sens, input logic [15:0] c_off,
                                  input logic [15:0] c_sens_tc, input logic [15:0] c_off_tc,
                                  input logic [15:0] c_tref, input logic [15:0] c_tslope);
    logic [15:0] words [NumCal];
    words = '{c_sens, c_off, c_sens_tc, c_off_tc, c_tref, c_tslope};
    for (int i = REG_SENS; i <= RegSpareHi; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      if (i < NumCal) begin
        cfg_data <= words[i];
        cal[i] = words[i];
      end else begin
        cfg_data <= 16'($urandom);
      end
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_calibration();
    load_calibration(rand_cal_word(), rand_cal_word(), rand_cal_word(),
                     rand_cal_word(), rand_cal_word(), rand_cal_word());
  endtask

  // all words zero straight out of reset
  task automatic test_reset_calibration();
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'd0);
    send_reading(24'd0, 24'hFFFFFF);
    send_reading(24'h800000, 24'h7FFFFF);
    drain_results();
  endtask

  task automatic test_branch_edges();
    load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'd0);
    send_reading(24'd0, 24'd0);
    drain_results();
    // typical factory words
    load_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
    send_reading(24'd4958179, 24'd6815414);
    send_reading(24'hFFFFFF, 24'd0);
    drain_results();
    // reference at 2^23, slope gives TEMP = 2000 + dT/1024
    load_calibration(16'd40000, 16'd30000, 16'd25000, 16'd20000, 16'h8000, 16'h2000);
    send_reading(24'hFFFFFF, 24'd8389631);  // high side, just above
    send_reading(24'h5A5A5A, 24'd8388608);  // dT zero
    send_reading(24'hFFFFFF, 24'd8388607);  // small negative dT truncates to TEMP 2000
    send_reading(24'h5A5A5A, 24'd8387584);  // TEMP 1999, low side
    send_reading(24'hFFFFFF, 24'd4804608);  // TEMP exactly -1500, not very low
    send_reading(24'h5A5A5A, 24'd4803585);  // truncation keeps TEMP at -1500
    send_reading(24'hFFFFFF, 24'd4803584);  // TEMP -1501, very low
    send_reading(24'd0, 24'd0);             // deepest very low
    drain_results();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < RandPhases; phase++) begin
      drain_results();
      load_random_calibration();
      gaps_on  = (phase % 3) != 2;
      stall_on = (phase % 4) != 1;
      repeat (PhaseItems) send_random_reading();
    end
  endtask

  // sender holds off mid-stream until the core has emptied
  task automatic test_pause_until_drained();
    drain_results();
    load_random_calibration();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    repeat (PauseItems) send_random_reading();
    drain_results();
    repeat (PauseItems) send_random_reading();
  endtask

  task automatic test_full_rate();
    drain_results();
    load_random_calibration();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (out_stall) @(negedge clk);
    repeat (FullRateItems) send_random_reading();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    raw_p     = 24'd0;
    raw_t     = 24'd0;
    cfg_we    = 1'b0;
    cfg_index = REG_SENS;
    cfg_data  = 16'd0;
    foreach (cal[i]) cal[i] = 16'd0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_calibration();
    test_branch_edges();
    test_random_phases();
    test_pause_until_drained();
    test_full_rate();

    drain_results();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[pressure_temp_compensation_core] OK");
    end else begin
      $display("[pressure_temp_compensation_core] ERROR");
    end
    $finish;
  end

endmodule

@@ pressure_temp_compensation_core.f @@
design/ptcomp_pkg.sv
design/pressure_temp_compensation_core.sv
tb/sv/pressure_temp_compensation_core_test.sv
